// ===== hdl/gpa_pkg.sv =====
// Shared types and constants for the GNSS point averager.
// Used by gpa_cfg, gpa_div, gnss_point_averager and gpa_checker; no dependencies.
package gpa_pkg;

  localparam int SUM_WIDTH  = 48;
  localparam int DIV_CNT_W  = $clog2(SUM_WIDTH + 1);
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int PCT_W      = 7;
  localparam int PCT_PROD_W = 16 + PCT_W;

  localparam logic [DIV_CNT_W-1:0] DIV_PCT_BITS = DIV_CNT_W'(PCT_PROD_W);
  localparam logic [DIV_CNT_W-1:0] DIV_SUM_BITS = DIV_CNT_W'(SUM_WIDTH);

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [15:0]      CNT_MAX   = 16'hFFFF;

  localparam logic [15:0] HOLD_WINDOW_RST  = 16'd5000;
  localparam logic [15:0] MAX_ACCURACY_RST = 16'd300;
  localparam logic [15:0] MIN_FIXES_RST    = 16'd5;

  localparam logic [1:0] REG_HOLD_WINDOW  = 2'd0;
  localparam logic [1:0] REG_MAX_ACCURACY = 2'd1;
  localparam logic [1:0] REG_MIN_FIXES    = 2'd2;

  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_ADD_FIX = 3'd1,
    CMD_POLL    = 3'd2,
    CMD_COMMIT  = 3'd3,
    CMD_CANCEL  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_DONE    = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] hold_window_ms;
    logic [15:0] max_accuracy_cm;
    logic [15:0] min_fixes;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
    logic [SUM_WIDTH-1:0] dividend;
    logic [15:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [SUM_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/gpa_cfg.sv =====
// APB-style configuration registers for the GNSS point averager.
// Depends on gpa_pkg for reset values, register indexes and cfg_t.
module gpa_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output gpa_pkg::cfg_t    cfg
);

  logic [15:0] hold_window_r;
  logic [15:0] max_accuracy_r;
  logic [15:0] min_fixes_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_window_r  <= gpa_pkg::HOLD_WINDOW_RST;
      max_accuracy_r <= gpa_pkg::MAX_ACCURACY_RST;
      min_fixes_r    <= gpa_pkg::MIN_FIXES_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        gpa_pkg::REG_HOLD_WINDOW:  hold_window_r  <= pwdata[15:0];
        gpa_pkg::REG_MAX_ACCURACY: max_accuracy_r <= pwdata[15:0];
        gpa_pkg::REG_MIN_FIXES:    min_fixes_r    <= pwdata[15:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gpa_pkg::REG_HOLD_WINDOW:  prdata = {16'd0, hold_window_r};
      gpa_pkg::REG_MAX_ACCURACY: prdata = {16'd0, max_accuracy_r};
      gpa_pkg::REG_MIN_FIXES:    prdata = {16'd0, min_fixes_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.hold_window_ms  = hold_window_r;
  assign cfg.max_accuracy_cm = max_accuracy_r;
  assign cfg.min_fixes       = min_fixes_r;

endmodule

// ===== hdl/gpa_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 16-bit divisor.
// Depends on gpa_pkg for div_req_t, div_rsp_t and the sum width.
module gpa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gpa_pkg::div_req_t   req,
  output gpa_pkg::div_rsp_t   rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [gpa_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [gpa_pkg::SUM_WIDTH-1:0] quo_r;
  logic [15:0]                   rem_r;
  logic [15:0]                   divisor_r;
  logic [16:0]                   rem_sh;
  logic [16:0]                   rem_diff;
  logic                          fits;

  // Dividend bits leave at the top of quo_r, quotient bits enter at the bottom.
  assign rem_sh   = {rem_r, quo_r[gpa_pkg::SUM_WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, divisor_r};
  assign rem_diff = rem_sh - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == {{(gpa_pkg::DIV_CNT_W-1){1'b0}}, 1'b1}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= 16'd0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[gpa_pkg::SUM_WIDTH-2:0], fits};
      rem_r <= fits ? rem_diff[15:0] : rem_sh[15:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hdl/gnss_point_averager.sv =====
// Top level of the GNSS point averager: command sequencer, capture state and
// output register. Depends on gpa_pkg, gpa_cfg and gpa_div.
//
// One command item is taken at a time; in_ready is high only while the
// sequencer is idle, and a finished result waits in its own output register so
// the next item can be taken before the result is read. Begin, add fix, poll,
// cancel and failed commits pass through the exec, status and finish states to
// the result register when the window is closed or the capture is idle; while
// the window is open the percent needs one pass of the shared divider. A
// successful commit runs the divider twice, once for each of the two means. The
// single shared bit-serial divider takes 23 steps for the percent and 48 steps
// per mean. Configuration is not latched per item, so a write takes effect on
// the next item and also on an item in progress.
module gnss_point_averager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_now_ms,
  input  logic [30:0] in_fix_lat,
  input  logic [31:0] in_fix_lon,
  input  logic [15:0] in_fix_accuracy_cm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_fix_accepted,
  output logic [6:0]  out_percent_elapsed,
  output logic        out_committed,
  output logic [30:0] out_mean_lat,
  output logic [31:0] out_mean_lon,
  output logic        out_failed_flag,
  output logic [15:0] out_accepted_count,
  output logic [15:0] out_rejected_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = gpa_pkg::SUM_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EXEC     = 10'b0000000010,
    S_STAT     = 10'b0000000100,
    S_PCT_GO   = 10'b0000001000,
    S_PCT_WAIT = 10'b0000010000,
    S_LAT_GO   = 10'b0000100000,
    S_LAT_WAIT = 10'b0001000000,
    S_LON_GO   = 10'b0010000000,
    S_LON_WAIT = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t                state_r, state_nxt;
  gpa_pkg::cfg_t         cfg;
  gpa_pkg::div_req_t     div_req;
  gpa_pkg::div_rsp_t     div_rsp;

  // Latched item
  logic [2:0]            cmd_r;
  logic [31:0]           now_r;
  logic [30:0]           lat_r;
  logic [31:0]           lon_r;
  logic [15:0]           acc_r;

  // Capture state
  logic                  capture_active_r;
  logic [31:0]           start_time_r;
  logic [SW-1:0]         lat_sum_r;
  logic [SW-1:0]         lon_sum_r;
  logic [15:0]           good_r;
  logic [15:0]           bad_r;
  logic                  failed_r;

  // Per-item working values
  logic                  accepted_r;
  logic                  commit_r;
  gpa_pkg::status_t      status_r;
  logic [6:0]            percent_r;
  logic [gpa_pkg::PCT_PROD_W-1:0] prod_r;
  logic [30:0]           mlat_r;
  logic [31:0]           mlon_r;

  // Result register
  logic                  out_valid_r;
  logic [1:0]            o_status_r;
  logic                  o_accepted_r;
  logic [6:0]            o_percent_r;
  logic                  o_committed_r;
  logic [30:0]           o_mlat_r;
  logic [31:0]           o_mlon_r;
  logic                  o_failed_r;
  logic [15:0]           o_good_r;
  logic [15:0]           o_bad_r;

  logic [31:0]           elapsed;
  logic                  win_open;
  logic                  acc_bad;
  logic                  done_now;
  logic                  load_out;
  logic [SW-1:0]         lat_mag;
  logic [SW-1:0]         lon_mag;
  logic                  q_neg;
  logic [SW-1:0]         q_fix;
  logic [gpa_pkg::PCT_PROD_W-1:0] pct_prod;

  gpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign elapsed  = now_r - start_time_r;
  assign win_open = capture_active_r && (elapsed[31:16] == 16'd0) &&
                    (elapsed[15:0] < cfg.hold_window_ms);
  assign acc_bad  = (acc_r == 16'd0) || (acc_r > cfg.max_accuracy_cm);
  assign done_now = capture_active_r && !win_open && (good_r >= cfg.min_fixes);
  assign pct_prod = {{gpa_pkg::PCT_W{1'b0}}, elapsed[15:0]} *
                    {16'd0, gpa_pkg::PCT_SCALE};

  assign lat_mag = lat_sum_r[SW-1] ? (~lat_sum_r + 1'b1) : lat_sum_r;
  assign lon_mag = lon_sum_r[SW-1] ? (~lon_sum_r + 1'b1) : lon_sum_r;
  assign q_neg   = (state_r == S_LAT_WAIT) ? lat_sum_r[SW-1] : lon_sum_r[SW-1];
  assign q_fix   = q_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_PCT_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = gpa_pkg::DIV_PCT_BITS;
        div_req.dividend = {prod_r, {(SW-gpa_pkg::PCT_PROD_W){1'b0}}};
        div_req.divisor  = cfg.hold_window_ms;
      end
      S_LAT_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = gpa_pkg::DIV_SUM_BITS;
        div_req.dividend = lat_mag;
        div_req.divisor  = good_r;
      end
      S_LON_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = gpa_pkg::DIV_SUM_BITS;
        div_req.dividend = lon_mag;
        div_req.divisor  = good_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_EXEC;
      S_EXEC:     state_nxt = S_STAT;
      S_STAT: begin
        if (win_open)                          state_nxt = S_PCT_GO;
        else if (commit_r && good_r != 16'd0) state_nxt = S_LAT_GO;
        else                                   state_nxt = S_FIN;
      end
      S_PCT_GO:   state_nxt = S_PCT_WAIT;
      S_PCT_WAIT: if (div_rsp.done) state_nxt = S_FIN;
      S_LAT_GO:   state_nxt = S_LAT_WAIT;
      S_LAT_WAIT: if (div_rsp.done) state_nxt = S_LON_GO;
      S_LON_GO:   state_nxt = S_LON_WAIT;
      S_LON_WAIT: if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:      if (load_out) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control and capture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      capture_active_r <= 1'b0;
      start_time_r     <= 32'd0;
      lat_sum_r        <= '0;
      lon_sum_r        <= '0;
      good_r           <= 16'd0;
      bad_r            <= 16'd0;
      failed_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      if (state_r == S_EXEC) begin
        case (cmd_r)
          gpa_pkg::CMD_BEGIN: begin
            capture_active_r <= 1'b1;
            start_time_r     <= now_r;
            lat_sum_r        <= '0;
            lon_sum_r        <= '0;
            good_r           <= 16'd0;
            bad_r            <= 16'd0;
            failed_r         <= 1'b0;
          end
          gpa_pkg::CMD_ADD_FIX: begin
            if (win_open) begin
              if (acc_bad) begin
                if (bad_r != gpa_pkg::CNT_MAX) bad_r <= bad_r + 1'b1;
              end else if (good_r != gpa_pkg::CNT_MAX) begin
                lat_sum_r <= lat_sum_r + {{(SW-gpa_pkg::LAT_W){lat_r[30]}}, lat_r};
                lon_sum_r <= lon_sum_r + {{(SW-gpa_pkg::LON_W){lon_r[31]}}, lon_r};
                good_r    <= good_r + 1'b1;
              end
            end
          end
          gpa_pkg::CMD_COMMIT: begin
            if (done_now) begin
              // keep sums and count for the divider; clear them once the means are out
              capture_active_r <= 1'b0;
              start_time_r     <= 32'd0;
              bad_r            <= 16'd0;
              failed_r         <= 1'b0;
            end else if (capture_active_r) begin
              capture_active_r <= 1'b0;
              start_time_r     <= 32'd0;
              lat_sum_r        <= '0;
              lon_sum_r        <= '0;
              good_r           <= 16'd0;
              bad_r            <= 16'd0;
              failed_r         <= 1'b1;
            end
          end
          gpa_pkg::CMD_CANCEL: begin
            capture_active_r <= 1'b0;
            start_time_r     <= 32'd0;
            lat_sum_r        <= '0;
            lon_sum_r        <= '0;
            good_r           <= 16'd0;
            bad_r            <= 16'd0;
            failed_r         <= 1'b0;
          end
          default: ;
        endcase
      end

      // Finish a successful commit: drop the sums once no mean still needs them
      if ((state_r == S_STAT && commit_r && good_r == 16'd0) ||
          (state_r == S_LON_WAIT && div_rsp.done)) begin
        lat_sum_r <= '0;
        lon_sum_r <= '0;
        good_r    <= 16'd0;
      end
    end
  end

  // Item and result datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      now_r <= in_now_ms;
      lat_r <= in_fix_lat;
      lon_r <= in_fix_lon;
      acc_r <= in_fix_accuracy_cm;
    end

    if (state_r == S_EXEC) begin
      accepted_r <= (cmd_r == gpa_pkg::CMD_ADD_FIX) && win_open && !acc_bad;
      commit_r   <= (cmd_r == gpa_pkg::CMD_COMMIT) && done_now;
      mlat_r     <= 31'd0;
      mlon_r     <= 32'd0;
    end

    if (state_r == S_STAT) begin
      prod_r <= pct_prod;
      if (!capture_active_r) begin
        status_r  <= gpa_pkg::ST_IDLE;
        percent_r <= 7'd0;
      end else if (win_open) begin
        status_r  <= gpa_pkg::ST_RUNNING;
        percent_r <= 7'd0;
      end else begin
        status_r  <= (good_r >= cfg.min_fixes) ? gpa_pkg::ST_DONE : gpa_pkg::ST_FAILED;
        percent_r <= gpa_pkg::PCT_FULL;
      end
    end

    if (state_r == S_PCT_WAIT && div_rsp.done) percent_r <= div_rsp.quotient[6:0];
    if (state_r == S_LAT_WAIT && div_rsp.done) mlat_r    <= q_fix[30:0];
    if (state_r == S_LON_WAIT && div_rsp.done) mlon_r    <= q_fix[31:0];

    if (load_out) begin
      o_status_r    <= status_r;
      o_accepted_r  <= accepted_r;
      o_percent_r   <= percent_r;
      o_committed_r <= commit_r;
      o_mlat_r      <= mlat_r;
      o_mlon_r      <= mlon_r;
      o_failed_r    <= failed_r;
      o_good_r      <= good_r;
      o_bad_r       <= bad_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_fix_accepted    = o_accepted_r;
  assign out_percent_elapsed = o_percent_r;
  assign out_committed       = o_committed_r;
  assign out_mean_lat        = o_mlat_r;
  assign out_mean_lon        = o_mlon_r;
  assign out_failed_flag     = o_failed_r;
  assign out_accepted_count  = o_good_r;
  assign out_rejected_count  = o_bad_r;

endmodule

// ===== hdl/gpa_checker.sv =====
// Port-level checks for the GNSS point averager, bound to the top level.
// Depends on gpa_pkg for status codes and on gnss_point_averager's ports.
module gpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_fix_accepted,
  input logic [6:0]  out_percent_elapsed,
  input logic        out_committed,
  input logic [30:0] out_mean_lat,
  input logic [31:0] out_mean_lon,
  input logic        out_failed_flag,
  input logic [15:0] out_accepted_count,
  input logic [15:0] out_rejected_count
);

  // A successful commit leaves the capture cleared and the failed flag down
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_committed |->
      out_status == gpa_pkg::ST_IDLE && out_accepted_count == 16'd0 &&
      out_rejected_count == 16'd0 && !out_failed_flag)
    else $error("commit result does not show a cleared capture");

  // Means are zero unless the item committed
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_committed |-> out_mean_lat == 31'd0 && out_mean_lon == 32'd0)
    else $error("mean shown without a commit");

  // An accepted fix was inside the open window
  a_accept_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_accepted |->
      out_status == gpa_pkg::ST_RUNNING && out_accepted_count != 16'd0 &&
      out_percent_elapsed < 7'd100)
    else $error("fix accepted outside a running window");

  // Percent is zero when idle, below 100 while running and 100 once the window has closed
  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_status == gpa_pkg::ST_IDLE && out_percent_elapsed == 7'd0) ||
      (out_status == gpa_pkg::ST_RUNNING && out_percent_elapsed < 7'd100) ||
      (out_status == gpa_pkg::ST_DONE && out_percent_elapsed == 7'd100) ||
      (out_status == gpa_pkg::ST_FAILED && out_percent_elapsed == 7'd100))
    else $error("percent does not match status");

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_lon) &&
      $stable(out_status) && $stable(out_accepted_count))
    else $error("result item changed while stalled");

endmodule

bind gnss_point_averager gpa_checker u_gpa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_fix_accepted    (out_fix_accepted),
  .out_percent_elapsed (out_percent_elapsed),
  .out_committed       (out_committed),
  .out_mean_lat        (out_mean_lat),
  .out_mean_lon        (out_mean_lon),
  .out_failed_flag     (out_failed_flag),
  .out_accepted_count  (out_accepted_count),
  .out_rejected_count  (out_rejected_count)
);
